// ===== rtl/websocket_frame_deframer_assert.svh =====
// Assertion macros for the WebSocket frame deframer.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`ifndef ASSERT_OFF
`define WSDF_ASSERT_SAME(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);
`define WSDF_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);
`else
`define WSDF_ASSERT_SAME(lbl, ant, cons, msg)
`define WSDF_ASSERT_NEXT(lbl, ant, cons, msg)
`endif
`endif

// ===== rtl/wsdf_pkg.sv =====
// Types, codes and constants of the WebSocket frame deframer.
package wsdf_pkg;

    localparam int          MSG_LEN_BITS_DEF  = 32;
    localparam int          MAX_W             = 32;
    localparam logic [31:0] MSG_LIMIT_RESET   = 32'd65536;
    localparam logic [6:0]  LEN_EXT16         = 7'd126;
    localparam logic [6:0]  LEN_EXT64         = 7'd127;
    localparam logic [6:0]  CTRL_MAX_LEN      = 7'd125;
    localparam logic [2:0]  EXT16_BYTES       = 3'd2;
    localparam logic [2:0]  EXT64_BYTES       = 3'd0;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_KEY,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [3:0] {
        OP_CONT   = 4'h0,
        OP_TEXT   = 4'h1,
        OP_BINARY = 4'h2,
        OP_CLOSE  = 4'h8,
        OP_PING   = 4'h9,
        OP_PONG   = 4'hA
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_PING  = 2'd1,
        KIND_CLOSE = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_TOO_LONG    = 4'd1,
        ST_UNMASKED    = 4'd2,
        ST_BAD_CONTROL = 4'd3,
        ST_STRAY_CONT  = 4'd4,
        ST_MSG_OPEN    = 4'd5,
        ST_MSG_LONG    = 4'd6,
        ST_BAD_OPCODE  = 4'd7,
        ST_CLOSED      = 4'd8
    } status_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        kind_t      kind;
        logic       frame_last;
        logic       message_end;
        status_t    status;
    } result_t;

    function automatic kind_t kind_of(input logic [3:0] op);
        kind_t k;
        k = KIND_DATA;
        if (op == OP_PING)
        begin
            k = KIND_PING;
        end
        else if (op == OP_CLOSE)
        begin
            k = KIND_CLOSE;
        end
        return k;
    endfunction

endpackage

// ===== rtl/wsdf_byte_if.sv =====
// Byte channel carrying received stream words.
interface wsdf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/wsdf_result_if.sv =====
// Result channel carrying deframed payload words and markers.
interface wsdf_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic [1:0] kind;
    logic       frame_last;
    logic       message_end;
    logic [3:0] status;

    modport source (output valid, output out_byte, output has_byte, output kind,
                    output frame_last, output message_end, output status, input ready);
    modport sink (input valid, input out_byte, input has_byte, input kind,
                  input frame_last, input message_end, input status, output ready);
endinterface

// ===== rtl/websocket_frame_deframer.sv =====
// WebSocket client-to-server frame deframer top level.
//
// Usage: received stream words enter on rx (valid/ready), one byte per word.
// Results leave on tx (valid/ready): unmasked payload bytes of data, ping and
// close frames, empty-frame markers, and a single status word on an error.
// The message size limit is written through cfg_we/cfg_data; the user must do
// so only while idle, which the block does not enforce. A word accepted from rx
// is held in the input register and decoded, and its result, if any, is offered
// from the result register. Throughput: one word per cycle while tx does not
// stall, set by the single decode stage between the input and result registers.
// Reset clears the parser, the open-message state and the halt flag and sets
// the message size limit to 65536. When tx stalls, the result register holds
// its word; the input register takes one more word if it is empty, then rx
// ready drops. After a close frame or any error, every further word is
// consumed silently until reset.
`include "websocket_frame_deframer_assert.svh"
module websocket_frame_deframer
    import wsdf_pkg::*;
#(
    parameter int MSG_LEN_BITS = MSG_LEN_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [MAX_W-1:0]  cfg_data,
    wsdf_byte_if.sink         rx,
    wsdf_result_if.source     tx
);

    localparam int CNT_W = (MSG_LEN_BITS < MAX_W) ? MSG_LEN_BITS : MAX_W;
    localparam int CMP_W = MAX_W + 1;

    logic [MAX_W-1:0] msg_limit_reg;

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;

    phase_t           phase_reg, phase_next;
    logic             fin_reg, fin_next;
    logic [3:0]       opcode_reg, opcode_next;
    logic             masked_reg, masked_next;
    logic [63:0]      raw_length_reg, raw_length_next;
    logic [2:0]       len_left_reg, len_left_next;
    logic [31:0]      mask_key_reg, mask_key_next;
    logic [1:0]       mask_index_reg, mask_index_next;
    logic [CNT_W-1:0] payload_left_reg, payload_left_next;
    logic             msg_open_reg, msg_open_next;
    logic [CNT_W-1:0] msg_bytes_reg, msg_bytes_next;
    logic             halted_reg, halted_next;

    logic             out_valid_reg, out_valid_next;
    result_t          out_res_reg;
    result_t          res;
    logic             emit;

    logic             step_go;
    logic             work;

    logic [63:0]      raw_cand;
    logic             masked_cand;
    status_t          len_status;
    logic             raw_over;
    logic             ctrl_bad;

    logic             hdr_data;
    logic [CNT_W:0]   total;
    logic             total_over;
    status_t          hdr_status;

    logic [7:0]       key_byte;
    logic [7:0]       unmasked;
    logic             pay_last;

    assign step_go = in_valid_reg && (!out_valid_reg || tx.ready);
    assign work    = step_go && !halted_reg;
    assign rx.ready = !in_valid_reg || step_go;

    assign in_valid_next = (rx.valid && rx.ready) || (in_valid_reg && !step_go);

    assign raw_cand    = (phase_reg == PH_HDR1) ? 64'(in_byte_reg[6:0])
                                                : {raw_length_reg[55:0], in_byte_reg};
    assign masked_cand = (phase_reg == PH_HDR1) ? in_byte_reg[7] : masked_reg;
    assign raw_over    = (|raw_cand[63:MAX_W]) || (raw_cand[MAX_W-1:0] > msg_limit_reg)
                         || (|raw_cand[63:MSG_LEN_BITS]);
    assign ctrl_bad    = opcode_reg[3] && ((|raw_cand[63:7]) || (raw_cand[6:0] > CTRL_MAX_LEN)
                                           || !fin_reg);

    always_comb
    begin
        if (raw_over)
        begin
            len_status = ST_TOO_LONG;
        end
        else if (!masked_cand)
        begin
            len_status = ST_UNMASKED;
        end
        else if (ctrl_bad)
        begin
            len_status = ST_BAD_CONTROL;
        end
        else
        begin
            len_status = ST_OK;
        end
    end

    assign total      = {1'b0, msg_bytes_reg} + {1'b0, raw_length_reg[CNT_W-1:0]};
    assign total_over = (CMP_W'(total) > CMP_W'(msg_limit_reg))
                        || ((MSG_LEN_BITS <= MAX_W) ? total[CNT_W] : 1'b0);

    always_comb
    begin
        hdr_data   = 1'b0;
        hdr_status = ST_OK;
        case (opcode_reg)
            OP_CONT:
            begin
                hdr_data = 1'b1;
                if (!msg_open_reg)
                begin
                    hdr_status = ST_STRAY_CONT;
                end
            end
            OP_TEXT, OP_BINARY:
            begin
                hdr_data = 1'b1;
                if (msg_open_reg)
                begin
                    hdr_status = ST_MSG_OPEN;
                end
            end
            OP_CLOSE, OP_PING, OP_PONG:
            begin
                hdr_data = 1'b0;
            end
            default:
            begin
                hdr_status = ST_BAD_OPCODE;
            end
        endcase
        if (hdr_data && hdr_status == ST_OK && total_over)
        begin
            hdr_status = ST_MSG_LONG;
        end
    end

    always_comb
    begin
        case (mask_index_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    assign unmasked = in_byte_reg ^ key_byte;
    assign pay_last = (payload_left_reg == CNT_W'(1));

    always_comb
    begin
        phase_next        = phase_reg;
        fin_next          = fin_reg;
        opcode_next       = opcode_reg;
        masked_next       = masked_reg;
        raw_length_next   = raw_length_reg;
        len_left_next     = len_left_reg;
        mask_key_next     = mask_key_reg;
        mask_index_next   = mask_index_reg;
        payload_left_next = payload_left_reg;
        msg_open_next     = msg_open_reg;
        msg_bytes_next    = msg_bytes_reg;
        halted_next       = halted_reg;
        emit              = 1'b0;
        res               = '{out_byte: 8'd0, has_byte: 1'b0, kind: KIND_DATA,
                              frame_last: 1'b0, message_end: 1'b0, status: ST_OK};
        if (work)
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    fin_next    = in_byte_reg[7];
                    opcode_next = in_byte_reg[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1, PH_EXT:
                begin
                    masked_next = masked_cand;
                    if (phase_reg == PH_HDR1 &&
                        (in_byte_reg[6:0] == LEN_EXT16 || in_byte_reg[6:0] == LEN_EXT64))
                    begin
                        raw_length_next = '0;
                        len_left_next   = (in_byte_reg[6:0] == LEN_EXT16) ? EXT16_BYTES
                                                                          : EXT64_BYTES;
                        phase_next      = PH_EXT;
                    end
                    else
                    begin
                        raw_length_next = raw_cand;
                        len_left_next   = (phase_reg == PH_EXT) ? len_left_reg - 3'd1
                                                                : len_left_reg;
                        if (phase_reg == PH_HDR1 || len_left_reg == 3'd1)
                        begin
                            if (len_status != ST_OK)
                            begin
                                halted_next = 1'b1;
                                emit        = 1'b1;
                                res.status  = len_status;
                            end
                            else
                            begin
                                phase_next      = PH_KEY;
                                mask_index_next = 2'd0;
                                mask_key_next   = '0;
                            end
                        end
                    end
                end
                PH_KEY:
                begin
                    mask_key_next   = {mask_key_reg[23:0], in_byte_reg};
                    mask_index_next = mask_index_reg + 2'd1;
                    if (mask_index_reg == 2'd3)
                    begin
                        if (hdr_status != ST_OK)
                        begin
                            halted_next = 1'b1;
                            emit        = 1'b1;
                            res.status  = hdr_status;
                        end
                        else
                        begin
                            if (hdr_data)
                            begin
                                msg_open_next  = !fin_reg;
                                msg_bytes_next = fin_reg ? '0 : total[CNT_W-1:0];
                            end
                            payload_left_next = raw_length_reg[CNT_W-1:0];
                            if (raw_length_reg[CNT_W-1:0] != '0)
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                            else
                            begin
                                phase_next = PH_HDR0;
                                if (opcode_reg == OP_CLOSE)
                                begin
                                    halted_next    = 1'b1;
                                    emit           = 1'b1;
                                    res.kind       = KIND_CLOSE;
                                    res.frame_last = 1'b1;
                                    res.status     = ST_CLOSED;
                                end
                                else if (opcode_reg != OP_PONG)
                                begin
                                    emit            = 1'b1;
                                    res.kind        = kind_of(opcode_reg);
                                    res.frame_last  = 1'b1;
                                    res.message_end = hdr_data && fin_reg;
                                end
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    mask_index_next   = mask_index_reg + 2'd1;
                    payload_left_next = payload_left_reg - CNT_W'(1);
                    if (pay_last)
                    begin
                        phase_next = PH_HDR0;
                    end
                    if (opcode_reg != OP_PONG)
                    begin
                        emit           = 1'b1;
                        res.out_byte   = unmasked;
                        res.has_byte   = 1'b1;
                        res.kind       = kind_of(opcode_reg);
                        res.frame_last = pay_last;
                        if (opcode_reg == OP_CLOSE)
                        begin
                            if (pay_last)
                            begin
                                halted_next = 1'b1;
                                res.status  = ST_CLOSED;
                            end
                        end
                        else
                        begin
                            res.message_end = pay_last && fin_reg &&
                                (opcode_reg inside {OP_CONT, OP_TEXT, OP_BINARY});
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase
        end
    end

    assign out_valid_next = emit || (out_valid_reg && !tx.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_limit_reg    <= MSG_LIMIT_RESET;
            in_valid_reg     <= 1'b0;
            phase_reg        <= PH_HDR0;
            fin_reg          <= 1'b0;
            opcode_reg       <= '0;
            masked_reg       <= 1'b0;
            raw_length_reg   <= '0;
            len_left_reg     <= '0;
            mask_key_reg     <= '0;
            mask_index_reg   <= '0;
            payload_left_reg <= '0;
            msg_open_reg     <= 1'b0;
            msg_bytes_reg    <= '0;
            halted_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                msg_limit_reg <= cfg_data;
            end
            in_valid_reg     <= in_valid_next;
            phase_reg        <= phase_next;
            fin_reg          <= fin_next;
            opcode_reg       <= opcode_next;
            masked_reg       <= masked_next;
            raw_length_reg   <= raw_length_next;
            len_left_reg     <= len_left_next;
            mask_key_reg     <= mask_key_next;
            mask_index_reg   <= mask_index_next;
            payload_left_reg <= payload_left_next;
            msg_open_reg     <= msg_open_next;
            msg_bytes_reg    <= msg_bytes_next;
            halted_reg       <= halted_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (emit)
        begin
            out_res_reg <= res;
        end
    end

    assign tx.valid       = out_valid_reg;
    assign tx.out_byte    = out_res_reg.out_byte;
    assign tx.has_byte    = out_res_reg.has_byte;
    assign tx.kind        = out_res_reg.kind;
    assign tx.frame_last  = out_res_reg.frame_last;
    assign tx.message_end = out_res_reg.message_end;
    assign tx.status      = out_res_reg.status;

    `WSDF_ASSERT_SAME(a_error_halts, out_valid_reg && out_res_reg.status != ST_OK, halted_reg, "non-ok status without halt")
    `WSDF_ASSERT_NEXT(a_halt_silent, halted_reg && !(out_valid_reg && !tx.ready), !out_valid_reg, "result after halt")
    `WSDF_ASSERT_SAME(a_payload_count, phase_reg == PH_PAYLOAD, payload_left_reg != '0, "payload phase with zero count")

endmodule
